// ===== hw/rtl/quadratic_root_solver_macros.svh =====
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// shared concurrent check forms, clocked on clk and off during reset
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// plain invariant that holds at every edge
`define QRS_CHECK(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// condition on the same edge implies a consequence
`define QRS_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// widths, latencies, result codes and pipeline word types of the solver
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int COEF_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAG_W     = COEF_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int DISC_W    = PROD_W + 1;
  localparam int ROOT_W    = (DISC_W + 1) / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int NUM_W     = ROOT_W + 2;
  localparam int DEN_W     = MAG_W + 1;
  localparam int QNUM_W    = NUM_W + FRAC_BITS;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = QNUM_W;

  localparam logic [QNUM_W-1:0] SAT_NEG = QNUM_W'(1) << (COEF_W - 1);
  localparam logic [QNUM_W-1:0] SAT_POS = SAT_NEG - QNUM_W'(1);
  localparam logic [COEF_W-1:0] ROOT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] ROOT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OUT_INFINITE = 3'd0,
    OUT_LIN_NONE = 3'd1,
    OUT_LIN_ONE  = 3'd2,
    OUT_TWO      = 3'd3,
    OUT_DOUBLE   = 3'd4,
    OUT_COMPLEX  = 3'd5
  } outcome_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [MAG_W-1:0]   am;
    logic [MAG_W-1:0]   bm;
    logic [MAG_W-1:0]   cm;
    logic               an;
    logic               bn;
    logic               cn;
  } meta_t;

  typedef struct packed {
    outcome_t outcome;
    logic     neg1;
    logic     neg2;
  } rmeta_t;

endpackage

`default_nettype wire

// ===== hw/rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c = 0 on signed Q16.16 coefficients
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_coef_a/b/c and pulse start. A word is taken at every edge with
//   start high; busy stays low, so a new word may enter every cycle.
//   Each word gives one result on out_outcome, out_root_one, out_root_two and
//   out_overflow, shown for exactly one cycle with out_valid high, in the
//   order the words came in.
//   The pipeline stages, in order, for Q16.16 coefficients:
//   magnitudes, products, discriminant, one stage per square root bit,
//   numerator setup, one stage per quotient bit, then saturation.
//   Throughput is one word per cycle; the square root and the two dividers
//   are fully pipelined.
//   The receiver cannot hold results off; no result waits on the output.
//   Synchronous reset empties the pipeline: words in flight are dropped
//   and out_valid is low until new words arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [qrs_pkg::COEF_W-1:0] in_coef_a,
  input  wire logic [qrs_pkg::COEF_W-1:0] in_coef_b,
  input  wire logic [qrs_pkg::COEF_W-1:0] in_coef_c,
  output logic                            out_valid,
  output logic [2:0]                      out_outcome,
  output logic [qrs_pkg::COEF_W-1:0]      out_root_one,
  output logic [qrs_pkg::COEF_W-1:0]      out_root_two,
  output logic                            out_overflow
);
  import qrs_pkg::*;
  `include "quadratic_root_solver_macros.svh"

  // stage 1: magnitudes
  logic  v1_r;
  meta_t m1_r;
  meta_t m1_nxt;

  always_comb begin
    m1_nxt         = '0;
    m1_nxt.outcome = OUT_INFINITE;
    m1_nxt.an      = in_coef_a[COEF_W-1];
    m1_nxt.bn      = in_coef_b[COEF_W-1];
    m1_nxt.cn      = in_coef_c[COEF_W-1];
    m1_nxt.am      = m1_nxt.an ? MAG_W'(-in_coef_a) : MAG_W'(in_coef_a);
    m1_nxt.bm      = m1_nxt.bn ? MAG_W'(-in_coef_b) : MAG_W'(in_coef_b);
    m1_nxt.cm      = m1_nxt.cn ? MAG_W'(-in_coef_c) : MAG_W'(in_coef_c);
  end

  // stage 2: products
  logic              v2_r;
  meta_t             m2_r;
  logic [PROD_W-1:0] bb_r;
  logic [PROD_W-1:0] ac_r;

  // stage 3: discriminant and class
  logic              v3_r;
  meta_t             m3_r;
  meta_t             m3_nxt;
  logic [DISC_W-1:0] disc_r;
  logic [DISC_W-1:0] disc_nxt;
  logic [PROD_W+1:0] ac4;
  logic [PROD_W+1:0] bbx;
  logic [PROD_W+1:0] dsum;
  logic [PROD_W+1:0] ddif;

  always_comb begin
    ac4      = {ac_r, 2'b00};
    bbx      = (PROD_W+2)'(bb_r);
    dsum     = bbx + ac4;
    ddif     = bbx - ac4;
    m3_nxt   = m2_r;
    disc_nxt = '0;
    if (m2_r.am == '0) begin
      if (m2_r.bm != '0) begin
        m3_nxt.outcome = OUT_LIN_ONE;
      end else if (m2_r.cm != '0) begin
        m3_nxt.outcome = OUT_LIN_NONE;
      end else begin
        m3_nxt.outcome = OUT_INFINITE;
      end
    end else if (m2_r.cm != '0 && m2_r.an != m2_r.cn) begin
      // a and c of opposite sign: -4ac adds
      m3_nxt.outcome = OUT_TWO;
      disc_nxt       = dsum[DISC_W-1:0];
    end else if (bbx > ac4) begin
      m3_nxt.outcome = OUT_TWO;
      disc_nxt       = ddif[DISC_W-1:0];
    end else if (bbx == ac4) begin
      m3_nxt.outcome = OUT_DOUBLE;
    end else begin
      m3_nxt.outcome = OUT_COMPLEX;
    end
  end

  // square root, with the side data delayed alongside
  logic [ROOT_W-1:0] sroot;
  logic              vs_r [SQRT_LAT];
  meta_t             ms_r [SQRT_LAT];

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .rad  (disc_r),
    .root (sroot)
  );

  // stage 4: numerators and divisor
  meta_t                   ms;
  logic signed [NUM_W-1:0] nbs;
  logic signed [NUM_W-1:0] sx;
  logic signed [NUM_W-1:0] ncx;
  logic signed [NUM_W-1:0] n1;
  logic signed [NUM_W-1:0] n2;
  logic [NUM_W-1:0]        n1m;
  logic [NUM_W-1:0]        n2m;
  logic [DEN_W-1:0]        den_nxt;
  logic                    dneg;
  rmeta_t                  rm4_nxt;
  logic                    v4_r;
  rmeta_t                  rm4_r;
  logic [QNUM_W-1:0]       qn1_r;
  logic [QNUM_W-1:0]       qn2_r;
  logic [DEN_W-1:0]        den_r;

  always_comb begin
    ms  = ms_r[SQRT_LAT-1];
    // nbs is -b, ncx is -c
    nbs = ms.bn ? signed'(NUM_W'(ms.bm)) : -signed'(NUM_W'(ms.bm));
    ncx = ms.cn ? signed'(NUM_W'(ms.cm)) : -signed'(NUM_W'(ms.cm));
    sx  = signed'(NUM_W'(sroot));
    n2  = '0;
    if (ms.outcome == OUT_LIN_ONE) begin
      n1      = ncx;
      den_nxt = DEN_W'(ms.bm);
      dneg    = ms.bn;
    end else begin
      n1      = (ms.outcome == OUT_TWO) ? nbs + sx : nbs;
      n2      = nbs - sx;
      den_nxt = {ms.am, 1'b0};
      dneg    = ms.an;
    end
    n1m             = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
    n2m             = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
    rm4_nxt.outcome = ms.outcome;
    rm4_nxt.neg1    = n1[NUM_W-1] != dneg;
    rm4_nxt.neg2    = n2[NUM_W-1] != dneg;
  end

  // dividers
  logic [QNUM_W-1:0] q1;
  logic [QNUM_W-1:0] q2;
  logic              vd_r [DIV_LAT];
  rmeta_t            rd_r [DIV_LAT];

  qrs_div u_div_one (
    .clk (clk),
    .num (qn1_r),
    .den (den_r),
    .quo (q1)
  );

  qrs_div u_div_two (
    .clk (clk),
    .num (qn2_r),
    .den (den_r),
    .quo (q2)
  );

  // stage 5: saturation and result select
  rmeta_t            rd;
  logic [QNUM_W-1:0] lim1;
  logic [QNUM_W-1:0] lim2;
  logic [QNUM_W-1:0] mag1;
  logic [QNUM_W-1:0] mag2;
  logic              ovf1;
  logic              ovf2;
  logic [COEF_W-1:0] r1;
  logic [COEF_W-1:0] r2;
  logic [COEF_W-1:0] root_one_nxt;
  logic [COEF_W-1:0] root_two_nxt;
  logic              overflow_nxt;
  logic              out_valid_r;
  logic [2:0]        out_outcome_r;
  logic [COEF_W-1:0] out_root_one_r;
  logic [COEF_W-1:0] out_root_two_r;
  logic              out_overflow_r;

  always_comb begin
    rd   = rd_r[DIV_LAT-1];
    lim1 = rd.neg1 ? SAT_NEG : SAT_POS;
    lim2 = rd.neg2 ? SAT_NEG : SAT_POS;
    ovf1 = q1 > lim1;
    ovf2 = q2 > lim2;
    mag1 = ovf1 ? lim1 : q1;
    mag2 = ovf2 ? lim2 : q2;
    r1   = rd.neg1 ? COEF_W'(-mag1) : COEF_W'(mag1);
    r2   = rd.neg2 ? COEF_W'(-mag2) : COEF_W'(mag2);
    case (rd.outcome)
      OUT_LIN_ONE, OUT_DOUBLE: begin
        root_one_nxt = r1;
        root_two_nxt = '0;
        overflow_nxt = ovf1;
      end
      OUT_TWO: begin
        root_one_nxt = r1;
        root_two_nxt = r2;
        overflow_nxt = ovf1 | ovf2;
      end
      default: begin
        root_one_nxt = '0;
        root_two_nxt = '0;
        overflow_nxt = 1'b0;
      end
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SQRT_LAT; k++) begin
        vs_r[k] <= 1'b0;
      end
      for (int k = 0; k < DIV_LAT; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else begin
      v1_r    <= start;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vs_r[0] <= v3_r;
      for (int k = 1; k < SQRT_LAT; k++) begin
        vs_r[k] <= vs_r[k-1];
      end
      v4_r    <= vs_r[SQRT_LAT-1];
      vd_r[0] <= v4_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
      out_valid_r <= vd_r[DIV_LAT-1];
    end
  end

  // data path
  always_ff @(posedge clk) begin
    m1_r     <= m1_nxt;
    m2_r     <= m1_r;
    bb_r     <= m1_r.bm * m1_r.bm;
    ac_r     <= m1_r.am * m1_r.cm;
    m3_r     <= m3_nxt;
    disc_r   <= disc_nxt;
    ms_r[0]  <= m3_r;
    for (int k = 1; k < SQRT_LAT; k++) begin
      ms_r[k] <= ms_r[k-1];
    end
    rm4_r    <= rm4_nxt;
    qn1_r    <= {n1m, {FRAC_BITS{1'b0}}};
    qn2_r    <= {n2m, {FRAC_BITS{1'b0}}};
    den_r    <= den_nxt;
    rd_r[0]  <= rm4_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      rd_r[k] <= rd_r[k-1];
    end
    out_outcome_r  <= rd.outcome;
    out_root_one_r <= root_one_nxt;
    out_root_two_r <= root_two_nxt;
    out_overflow_r <= overflow_nxt;
  end

  assign busy         = 1'b0;
  assign out_valid    = out_valid_r;
  assign out_outcome  = out_outcome_r;
  assign out_root_one = out_root_one_r;
  assign out_root_two = out_root_two_r;
  assign out_overflow = out_overflow_r;

  // result classes seen by the checks
  logic res_two;
  logic res_rootless;
  logic res_quiet;
  logic res_sat;

  assign res_two      = out_outcome == OUT_TWO;
  assign res_rootless = out_outcome == OUT_INFINITE || out_outcome == OUT_LIN_NONE ||
                        out_outcome == OUT_COMPLEX;
  assign res_quiet    = out_root_one == '0 && !out_overflow;
  assign res_sat      = out_root_one == ROOT_MAX || out_root_one == ROOT_MIN ||
                        out_root_two == ROOT_MAX || out_root_two == ROOT_MIN;

  `QRS_IMPLY(a_root_two_only_two, out_valid && !res_two, out_root_two == '0, "root_two set")
  `QRS_IMPLY(a_no_root_quiet, out_valid && res_rootless, res_quiet, "root on rootless word")
  `QRS_IMPLY(a_ovf_saturated, out_valid && out_overflow, res_sat, "overflow unsaturated")
  `QRS_CHECK(a_never_busy, !busy, "busy raised")

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt (
  input  wire logic                       clk,
  input  wire logic [qrs_pkg::DISC_W-1:0] rad,
  output logic      [qrs_pkg::ROOT_W-1:0] root
);
  import qrs_pkg::*;

  logic [2*ROOT_W-1:0] rad_r  [SQRT_LAT];
  logic [REM_W-1:0]    rem_r  [SQRT_LAT];
  logic [ROOT_W-1:0]   root_r [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    logic [2*ROOT_W-1:0] prev_rad;
    logic [REM_W-1:0]    prev_rem;
    logic [ROOT_W-1:0]   prev_root;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;

    if (i == 0) begin : g_first
      assign prev_rad  = (2*ROOT_W)'(rad);
      assign prev_rem  = '0;
      assign prev_root = '0;
    end else begin : g_next
      assign prev_rad  = rad_r[i-1];
      assign prev_rem  = rem_r[i-1];
      assign prev_root = root_r[i-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {prev_rem[REM_W-3:0], prev_rad[2*ROOT_W-1 -: 2]};
    assign trial  = {1'b0, prev_root, 2'b01};

    always_ff @(posedge clk) begin
      rad_r[i] <= prev_rad << 2;
      if (rem_sh >= trial) begin
        rem_r[i]  <= rem_sh - trial;
        root_r[i] <= {prev_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[i]  <= rem_sh;
        root_r[i] <= {prev_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div (
  input  wire logic                       clk,
  input  wire logic [qrs_pkg::QNUM_W-1:0] num,
  input  wire logic [qrs_pkg::DEN_W-1:0]  den,
  output logic      [qrs_pkg::QNUM_W-1:0] quo
);
  import qrs_pkg::*;

  logic [QNUM_W-1:0] num_r [DIV_LAT];
  logic [DEN_W-1:0]  den_r [DIV_LAT];
  logic [DEN_W-1:0]  rem_r [DIV_LAT];
  logic [QNUM_W-1:0] quo_r [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [QNUM_W-1:0] prev_num;
    logic [DEN_W-1:0]  prev_den;
    logic [DEN_W-1:0]  prev_rem;
    logic [QNUM_W-1:0] prev_quo;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;

    if (i == 0) begin : g_first
      assign prev_num = num;
      assign prev_den = den;
      assign prev_rem = '0;
      assign prev_quo = '0;
    end else begin : g_next
      assign prev_num = num_r[i-1];
      assign prev_den = den_r[i-1];
      assign prev_rem = rem_r[i-1];
      assign prev_quo = quo_r[i-1];
    end

    assign rem_sh = {prev_rem, prev_num[QNUM_W-1]};
    assign diff   = rem_sh - {1'b0, prev_den};

    always_ff @(posedge clk) begin
      num_r[i] <= prev_num << 1;
      den_r[i] <= prev_den;
      if (rem_sh >= {1'b0, prev_den}) begin
        rem_r[i] <= diff[DEN_W-1:0];
        quo_r[i] <= {prev_quo[QNUM_W-2:0], 1'b1};
      end else begin
        rem_r[i] <= rem_sh[DEN_W-1:0];
        quo_r[i] <= {prev_quo[QNUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

`default_nettype wire
